// ===== sv/atrsp_pkg.sv =====
package atrsp_pkg;

   localparam int unsigned BUFFER_DEPTH_DEF = 1024;
   localparam int unsigned MAX_PAYLOAD_DEF  = 31;

   // input item codes
   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // response end markers, all starting with CR LF
   localparam int unsigned MARK_COUNT   = 5;
   localparam int unsigned MARK_MAX_LEN = 9;
   localparam int unsigned MARK_SEL_W   = $clog2(MARK_COUNT);
   localparam int unsigned MARK_LEN_W   = $clog2(MARK_MAX_LEN + 1);

   localparam logic [MARK_SEL_W-1:0] MARK_OK = MARK_SEL_W'(0);

   localparam logic [7:0] MARK_TEXT [MARK_COUNT][MARK_MAX_LEN] = '{
      '{8'h0D, 8'h0A, 8'h4F, 8'h4B, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00},  // OK
      '{8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h00, 8'h00},  // ERROR
      '{8'h0D, 8'h0A, 8'h46, 8'h41, 8'h49, 8'h4C, 8'h00, 8'h00, 8'h00},  // FAIL
      '{8'h0D, 8'h0A, 8'h53, 8'h45, 8'h4E, 8'h44, 8'h20, 8'h4F, 8'h4B},  // SEND OK
      '{8'h0D, 8'h0A, 8'h62, 8'h75, 8'h73, 8'h79, 8'h00, 8'h00, 8'h00}   // busy
   };

   localparam logic [MARK_LEN_W-1:0] MARK_LEN [MARK_COUNT] = '{
      MARK_LEN_W'(6), MARK_LEN_W'(7), MARK_LEN_W'(6), MARK_LEN_W'(9), MARK_LEN_W'(6)
   };

   // frame header tag "+IPD,"
   localparam int unsigned TAG_LEN = 5;
   localparam int unsigned TAG_W   = $clog2(TAG_LEN);
   localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
   localparam logic [TAG_W-1:0] TAG_LAST = TAG_W'(TAG_LEN - 1);

   // frame parser phases
   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_LINK = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   typedef struct packed {
      logic       response_ready;
      logic       buffer_full;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] link_id;
      logic       payload_last;
      logic       frame_rejected;
   } rsp_type;

endpackage

// ===== sv/atrsp_req_if.sv =====
interface atrsp_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// ===== sv/atrsp_rsp_if.sv =====
interface atrsp_rsp_if;
   logic       valid;
   logic       ready;
   logic       response_ready;
   logic       buffer_full;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] link_id;
   logic       payload_last;
   logic       frame_rejected;

   modport source (output valid, output response_ready, output buffer_full,
                   output payload_valid, output payload_byte, output link_id,
                   output payload_last, output frame_rejected, input ready);
   modport sink (input valid, input response_ready, input buffer_full,
                 input payload_valid, input payload_byte, input link_id,
                 input payload_last, input frame_rejected, output ready);
endinterface

// ===== sv/at_response_stream_parser_unit.sv =====
// A req beat is loaded into the input register at its accepting edge, and its rsp
// beat is then loaded into the result register once the rsp side can take it.
// Throughput: one beat per cycle while rsp.ready holds; every req beat yields one rsp beat.
// The only loop is the state update between the two registers.
// Reset (synchronous, active high) clears both pipeline stages, the byte count,
// the ready flag, the marker matcher, the frame parser and server_mode.
module at_response_stream_parser_unit #(
   parameter int unsigned BUFFER_DEPTH = atrsp_pkg::BUFFER_DEPTH_DEF,
   parameter int unsigned MAX_PAYLOAD  = atrsp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   atrsp_req_if.sink   req,
   atrsp_rsp_if.source rsp,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import atrsp_pkg::*;

   localparam int unsigned CNT_W  = $clog2(BUFFER_DEPTH);
   localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 2);
   localparam int unsigned LM_W   = LEN_W + 4;
   localparam int unsigned LEFT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(BUFFER_DEPTH - 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);
   localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_PAYLOAD + 1);

   // handshake and pipeline
   logic       in_valid_ff, in_valid_in;
   logic       in_func_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       advance;
   logic       server_mode_ff;

   // block state
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ready_ff, ready_in;
   logic [MARK_SEL_W-1:0] mark_sel_ff, mark_sel_in;
   logic [MARK_LEN_W-1:0] mark_len_ff, mark_len_in;
   logic [1:0]            phase_ff, phase_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic [7:0]            link_ff, link_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEFT_W-1:0]     left_ff, left_in;

   // matcher result for the byte in the input register
   logic [MARK_SEL_W-1:0] mk_sel;
   logic [MARK_LEN_W-1:0] mk_len;
   logic                  mk_hit;

   logic [7:0]      c;
   logic            is_digit;
   logic [11:0]     link_mul;
   logic [LM_W-1:0] len_mul;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready    = !in_valid_ff || advance;
   assign in_valid_in  = (in_valid_ff && !advance) || (req.valid && req.ready);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   assign c        = in_byte_ff;
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign link_mul = ({4'b0, link_ff} << 3) + ({4'b0, link_ff} << 1) + {8'b0, c[3:0]};
   assign len_mul  = ({4'b0, len_ff} << 3) + ({4'b0, len_ff} << 1) + LM_W'(c[3:0]);

   // Matcher keeps the longest tail that is a prefix of some marker as
   // (marker, length). All markers share CR LF, and after a mismatch the only
   // tail that can survive is a lone CR.
   always_comb begin
      mk_sel = MARK_OK;
      mk_len = (c == CHAR_CR) ? MARK_LEN_W'(1) : MARK_LEN_W'(0);
      mk_hit = 1'b0;
      if (mark_len_ff == MARK_LEN_W'(1)) begin
         if (c == CHAR_LF) begin
            mk_len = MARK_LEN_W'(2);
         end
      end else if (mark_len_ff == MARK_LEN_W'(2)) begin
         for (int m = 0; m < MARK_COUNT; m++) begin
            if (c == MARK_TEXT[m][2]) begin
               mk_sel = MARK_SEL_W'(m);
               mk_len = MARK_LEN_W'(3);
            end
         end
      end else if (mark_len_ff >= MARK_LEN_W'(3)) begin
         if (c == MARK_TEXT[mark_sel_ff][mark_len_ff]) begin
            if (mark_len_ff + MARK_LEN_W'(1) == MARK_LEN[mark_sel_ff]) begin
               mk_hit = 1'b1;
               // "OK" marker ends in CR LF, which starts the next marker
               mk_len = (mark_sel_ff == MARK_OK) ? MARK_LEN_W'(2) : MARK_LEN_W'(0);
            end else begin
               mk_sel = mark_sel_ff;
               mk_len = mark_len_ff + MARK_LEN_W'(1);
            end
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      ready_in    = ready_ff;
      mark_sel_in = mark_sel_ff;
      mark_len_in = mark_len_ff;
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      link_in     = link_ff;
      len_in      = len_ff;
      left_in     = left_ff;
      out_in      = '0;
      if (in_func_ff == FUNC_FLUSH) begin
         count_in    = '0;
         ready_in    = 1'b0;
         mark_sel_in = MARK_OK;
         mark_len_in = '0;
         phase_in    = PH_HUNT;
         tag_in      = '0;
         link_in     = '0;
         len_in      = '0;
         left_in     = '0;
      end else begin
         if (count_ff != CNT_TOP) begin
            count_in    = count_ff + CNT_W'(1);
            mark_sel_in = mk_sel;
            mark_len_in = mk_len;
         end
         if (!server_mode_ff) begin
            if ((count_ff != CNT_TOP && mk_hit) || count_in == CNT_TOP) begin
               ready_in = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (c == TAG_TEXT[tag_ff]) begin
                     if (tag_ff == TAG_LAST) begin
                        phase_in = PH_LINK;
                        tag_in   = '0;
                        link_in  = '0;
                        len_in   = '0;
                     end else begin
                        tag_in = tag_ff + TAG_W'(1);
                     end
                  end else begin
                     tag_in = (c == CHAR_PLUS) ? TAG_W'(1) : TAG_W'(0);
                  end
               end
               PH_LINK: begin
                  // tag_ff flags that at least one digit was seen
                  if (is_digit) begin
                     link_in = (link_mul > 12'd255) ? 8'hFF : link_mul[7:0];
                     tag_in  = TAG_W'(1);
                  end else if (c == CHAR_COMMA && tag_ff == TAG_W'(1)) begin
                     phase_in = PH_LEN;
                     tag_in   = '0;
                  end else begin
                     out_in.frame_rejected = 1'b1;
                     phase_in = PH_HUNT;
                     tag_in   = (c == CHAR_PLUS) ? TAG_W'(1) : TAG_W'(0);
                     link_in  = '0;
                     len_in   = '0;
                  end
               end
               PH_LEN: begin
                  if (is_digit) begin
                     len_in = (len_mul > {4'b0, LEN_SAT}) ? LEN_SAT : len_mul[LEN_W-1:0];
                     tag_in = TAG_W'(1);
                  end else if (c == CHAR_COLON && tag_ff == TAG_W'(1) &&
                               len_ff != '0 && len_ff <= LEN_MAX) begin
                     phase_in = PH_DATA;
                     tag_in   = '0;
                     left_in  = len_ff[LEFT_W-1:0];
                  end else begin
                     out_in.frame_rejected = 1'b1;
                     phase_in = PH_HUNT;
                     tag_in   = (c == CHAR_PLUS) ? TAG_W'(1) : TAG_W'(0);
                     link_in  = '0;
                     len_in   = '0;
                  end
               end
               PH_DATA: begin
                  out_in.payload_valid = 1'b1;
                  out_in.payload_byte  = c;
                  out_in.link_id       = link_ff;
                  if (left_ff <= LEFT_W'(1)) begin
                     out_in.payload_last = 1'b1;
                     left_in  = '0;
                     phase_in = PH_HUNT;
                     tag_in   = '0;
                     link_in  = '0;
                     len_in   = '0;
                  end else begin
                     left_in = left_ff - LEFT_W'(1);
                  end
               end
            endcase
         end
         out_in.response_ready = ready_in;
         out_in.buffer_full    = (count_in == CNT_TOP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         server_mode_ff <= 1'b0;
         count_ff       <= '0;
         ready_ff       <= 1'b0;
         mark_sel_ff    <= MARK_OK;
         mark_len_ff    <= '0;
         phase_ff       <= PH_HUNT;
         tag_ff         <= '0;
         link_ff        <= '0;
         len_ff         <= '0;
         left_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            server_mode_ff <= csr_write_data;
         end
         if (advance) begin
            count_ff    <= count_in;
            ready_ff    <= ready_in;
            mark_sel_ff <= mark_sel_in;
            mark_len_ff <= mark_len_in;
            phase_ff    <= phase_in;
            tag_ff      <= tag_in;
            link_ff     <= link_in;
            len_ff      <= len_in;
            left_ff     <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_func_ff <= req.func;
         in_byte_ff <= req.rx_byte;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.response_ready = out_ff.response_ready;
   assign rsp.buffer_full    = out_ff.buffer_full;
   assign rsp.payload_valid  = out_ff.payload_valid;
   assign rsp.payload_byte   = out_ff.payload_byte;
   assign rsp.link_id        = out_ff.link_id;
   assign rsp.payload_last   = out_ff.payload_last;
   assign rsp.frame_rejected = out_ff.frame_rejected;

endmodule

// ===== sv/atrsp_checker.sv =====
module atrsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       response_ready,
   input logic       buffer_full,
   input logic       payload_valid,
   input logic [7:0] payload_byte,
   input logic [7:0] link_id,
   input logic       payload_last,
   input logic       frame_rejected
);

   // nothing left in flight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat valid right after reset");

   // non-payload beats carry zeroed payload fields
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !payload_valid |-> payload_byte == 8'h00 && link_id == 8'h00 && !payload_last)
      else $error("payload fields set on a beat without payload");

   // a rejected header never carries payload, and last implies payload
   a_reject_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (frame_rejected || payload_last) |-> payload_valid != frame_rejected)
      else $error("frame_rejected and payload flags conflict");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(response_ready) &&
         $stable(buffer_full) && $stable(payload_valid) && $stable(payload_byte) &&
         $stable(link_id) && $stable(payload_last) && $stable(frame_rejected))
      else $error("stalled rsp beat changed");

endmodule

bind at_response_stream_parser_unit atrsp_checker u_atrsp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .response_ready (rsp.response_ready),
   .buffer_full    (rsp.buffer_full),
   .payload_valid  (rsp.payload_valid),
   .payload_byte   (rsp.payload_byte),
   .link_id        (rsp.link_id),
   .payload_last   (rsp.payload_last),
   .frame_rejected (rsp.frame_rejected)
);
